[sv/tpl_pkg.sv]
package tpl_pkg;

    // Configuration register widths and indexes
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int INC_TOL_W    = 63;
    localparam int EDGE_TOL_W   = 34;

    localparam logic [CFG_IDX_W-1:0] REG_INCIRCLE_TOL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOL     = 8'd1;

    // Result layout
    localparam int AREA_W       = 34;
    localparam int OUT_FIELDS_W = 2 + 1 + 1 + AREA_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef enum logic [1:0] {
        LOC_OUTSIDE = 2'd0,
        LOC_INSIDE  = 2'd1,
        LOC_EDGE    = 2'd2
    } loc_t;

    // Vertex order and orientation tolerance flags of the ordered triangle
    typedef struct packed {
        logic swapped;
        logic ab_gt;
        logic ab_lt;
        logic bc_gt;
        logic bc_lt;
        logic ca_gt;
        logic ca_lt;
    } tpl_side_t;

endpackage

[sv/triangle_point_locate.sv]
// Locates a query point P against triangle A, B, C. B and C are exchanged when
// the cross product (B-A)x(C-A) is below edge_tol, twice the area is reported,
// and P counts as in the circumcircle when the exact lifted incircle determinant
// exceeds incircle_tol; only then do the edge orientations AB, BC, CA (against
// +/-edge_tol) report inside, on one edge or outside. The datapath is an
// eight-stage pipeline (differences, products, sums, vertex ordering, partial
// products, terms, determinant, classification) with a valid bit per stage, so
// one transaction is accepted per clock when the output is not stalled; the
// deepest stage is one multiplier of about (2W+3) x (W+2) bits. s_tdata
// carries ax, ay, bx, by_coord, cx, cy, px, py, COORD_WIDTH bits each, ax
// lowest. m_tdata carries location [1:0] (0 outside, 1 inside, 2 on an
// edge), in_circle [2], swapped [3], double_area [37:4], zeros above. Write
// the tolerances through the cfg channel (index 0 incircle_tol, index 1
// edge_tol) only while no transaction is in flight; both reset to zero.
module triangle_point_locate #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ax, ay, bx, by_coord, cx, cy, px, py from the lowest bit up
    input  logic [8*COORD_WIDTH-1:0]            s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // location, in_circle, swapped, double_area, zero pad from the lowest bit up
    output logic [tpl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int OW = 2 * COORD_WIDTH + 3;
    localparam int EW = 2 * COORD_WIDTH + 2;

    logic [tpl_pkg::INC_TOL_W-1:0]  incircle_tol_reg, incircle_tol_next;
    logic [tpl_pkg::EDGE_TOL_W-1:0] edge_tol_reg, edge_tol_next;

    logic                  g_valid, g_ready;
    logic signed [OW-1:0]  g_cross, g_ab, g_bc, g_ca;
    logic        [EW-1:0]  g_e1, g_e2, g_e3;

    logic                  o_valid, o_ready;
    logic signed [OW-1:0]  o_ab, o_bc, o_ca;
    logic        [EW-1:0]  o_e1, o_e2, o_e3;
    tpl_pkg::tpl_side_t    o_side;
    logic [tpl_pkg::AREA_W-1:0] o_area;

    tpl_pkg::loc_t         out_location;
    logic                  out_in_circle;
    logic                  out_swapped;
    logic [tpl_pkg::AREA_W-1:0] out_area;

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_comb begin
        incircle_tol_next = incircle_tol_reg;
        edge_tol_next     = edge_tol_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                tpl_pkg::REG_INCIRCLE_TOL: incircle_tol_next = cfg_data[tpl_pkg::INC_TOL_W-1:0];
                tpl_pkg::REG_EDGE_TOL:     edge_tol_next     = cfg_data[tpl_pkg::EDGE_TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            incircle_tol_reg <= '0;
            edge_tol_reg     <= '0;
        end else begin
            incircle_tol_reg <= incircle_tol_next;
            edge_tol_reg     <= edge_tol_next;
        end
    end

    tpl_geom #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .ax        ($signed(s_tdata[0*W +: W])),
        .ay        ($signed(s_tdata[1*W +: W])),
        .bx        ($signed(s_tdata[2*W +: W])),
        .by_coord  ($signed(s_tdata[3*W +: W])),
        .cx        ($signed(s_tdata[4*W +: W])),
        .cy        ($signed(s_tdata[5*W +: W])),
        .px        ($signed(s_tdata[6*W +: W])),
        .py        ($signed(s_tdata[7*W +: W])),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .cross_prod(g_cross),
        .ab        (g_ab),
        .bc        (g_bc),
        .ca        (g_ca),
        .e1        (g_e1),
        .e2        (g_e2),
        .e3        (g_e3)
    );

    tpl_order #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_order (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edge_tol  (edge_tol_reg),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .cross_prod(g_cross),
        .ab        (g_ab),
        .bc        (g_bc),
        .ca        (g_ca),
        .e1        (g_e1),
        .e2        (g_e2),
        .e3        (g_e3),
        .out_valid (o_valid),
        .out_ready (o_ready),
        .ab_out    (o_ab),
        .bc_out    (o_bc),
        .ca_out    (o_ca),
        .e1_out    (o_e1),
        .e2_out    (o_e2),
        .e3_out    (o_e3),
        .side      (o_side),
        .area      (o_area)
    );

    tpl_incircle #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_incircle (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .incircle_tol (incircle_tol_reg),
        .in_valid     (o_valid),
        .in_ready     (o_ready),
        .ab           (o_ab),
        .bc           (o_bc),
        .ca           (o_ca),
        .e1           (o_e1),
        .e2           (o_e2),
        .e3           (o_e3),
        .side         (o_side),
        .area         (o_area),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .location     (out_location),
        .in_circle    (out_in_circle),
        .swapped      (out_swapped),
        .double_area  (out_area)
    );

    // Pack the result fields
    assign m_tdata = {{tpl_pkg::OUT_PAD_W{1'b0}}, out_area, out_swapped, out_in_circle,
                      out_location};

`ifndef SYNTHESIS
    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A taken output frees every stage, so the input must be open
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is taken");

    // Inside or on an edge is only reported within the circumcircle
    a_loc_circle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_location != tpl_pkg::LOC_OUTSIDE |-> out_in_circle)
        else $error("location reported outside circumcircle");

    // An edge tolerance write lands in the register
    a_edge_tol_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && cfg_index == tpl_pkg::REG_EDGE_TOL
        |=> edge_tol_reg == $past(cfg_data[tpl_pkg::EDGE_TOL_W-1:0]))
        else $error("edge tolerance write lost");
`endif

endmodule

[sv/tpl_geom.sv]
module tpl_geom #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_WIDTH-1:0]       ax,
    input  logic signed [COORD_WIDTH-1:0]       ay,
    input  logic signed [COORD_WIDTH-1:0]       bx,
    input  logic signed [COORD_WIDTH-1:0]       by_coord,
    input  logic signed [COORD_WIDTH-1:0]       cx,
    input  logic signed [COORD_WIDTH-1:0]       cy,
    input  logic signed [COORD_WIDTH-1:0]       px,
    input  logic signed [COORD_WIDTH-1:0]       py,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [2*COORD_WIDTH+2:0]     cross_prod,
    output logic signed [2*COORD_WIDTH+2:0]     ab,
    output logic signed [2*COORD_WIDTH+2:0]     bc,
    output logic signed [2*COORD_WIDTH+2:0]     ca,
    output logic        [2*COORD_WIDTH+1:0]     e1,
    output logic        [2*COORD_WIDTH+1:0]     e2,
    output logic        [2*COORD_WIDTH+1:0]     e3
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int OW = 2 * COORD_WIDTH + 3;
    localparam int EW = 2 * COORD_WIDTH + 2;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    // Stage 1: coordinate differences
    logic signed [DW-1:0] bax_next, cay_next, bay_next, cax_next;
    logic signed [DW-1:0] dax_next, day_next, dbx_next, dby_next, dcx_next, dcy_next;
    logic signed [DW-1:0] bax_reg, cay_reg, bay_reg, cax_reg;
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg, dcx_reg, dcy_reg;

    // Stage 2: products
    logic signed [PW-1:0] cr1_next, cr2_next, ab1_next, ab2_next, bc1_next, bc2_next;
    logic signed [PW-1:0] ca1_next, ca2_next;
    logic signed [PW-1:0] sax_next, say_next, sbx_next, sby_next, scx_next, scy_next;
    logic signed [PW-1:0] cr1_reg, cr2_reg, ab1_reg, ab2_reg, bc1_reg, bc2_reg;
    logic signed [PW-1:0] ca1_reg, ca2_reg;
    logic signed [PW-1:0] sax_reg, say_reg, sbx_reg, sby_reg, scx_reg, scy_reg;

    // Stage 3: sums
    logic signed [OW-1:0] cross_next, ab_next, bc_next, ca_next;
    logic        [EW-1:0] e1_next, e2_next, e3_next;
    logic signed [OW-1:0] cross_reg, ab_reg, bc_reg, ca_reg;
    logic        [EW-1:0] e1_reg, e2_reg, e3_reg;

    // Advance a stage when it is empty or the one after it moves
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_comb begin
        bax_next = DW'(bx) - DW'(ax);
        cay_next = DW'(cy) - DW'(ay);
        bay_next = DW'(by_coord) - DW'(ay);
        cax_next = DW'(cx) - DW'(ax);
        dax_next = DW'(ax) - DW'(px);
        day_next = DW'(ay) - DW'(py);
        dbx_next = DW'(bx) - DW'(px);
        dby_next = DW'(by_coord) - DW'(py);
        dcx_next = DW'(cx) - DW'(px);
        dcy_next = DW'(cy) - DW'(py);
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            bax_reg <= bax_next;
            cay_reg <= cay_next;
            bay_reg <= bay_next;
            cax_reg <= cax_next;
            dax_reg <= dax_next;
            day_reg <= day_next;
            dbx_reg <= dbx_next;
            dby_reg <= dby_next;
            dcx_reg <= dcx_next;
            dcy_reg <= dcy_next;
        end
    end

    always_comb begin
        cr1_next = PW'(bax_reg) * PW'(cay_reg);
        cr2_next = PW'(bay_reg) * PW'(cax_reg);
        ab1_next = PW'(dax_reg) * PW'(dby_reg);
        ab2_next = PW'(day_reg) * PW'(dbx_reg);
        bc1_next = PW'(dbx_reg) * PW'(dcy_reg);
        bc2_next = PW'(dby_reg) * PW'(dcx_reg);
        ca1_next = PW'(dcx_reg) * PW'(day_reg);
        ca2_next = PW'(dax_reg) * PW'(dcy_reg);
        sax_next = PW'(dax_reg) * PW'(dax_reg);
        say_next = PW'(day_reg) * PW'(day_reg);
        sbx_next = PW'(dbx_reg) * PW'(dbx_reg);
        sby_next = PW'(dby_reg) * PW'(dby_reg);
        scx_next = PW'(dcx_reg) * PW'(dcx_reg);
        scy_next = PW'(dcy_reg) * PW'(dcy_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            cr1_reg <= cr1_next;
            cr2_reg <= cr2_next;
            ab1_reg <= ab1_next;
            ab2_reg <= ab2_next;
            bc1_reg <= bc1_next;
            bc2_reg <= bc2_next;
            ca1_reg <= ca1_next;
            ca2_reg <= ca2_next;
            sax_reg <= sax_next;
            say_reg <= say_next;
            sbx_reg <= sbx_next;
            sby_reg <= sby_next;
            scx_reg <= scx_next;
            scy_reg <= scy_next;
        end
    end

    // Squares are never negative, so their sums are taken unsigned
    always_comb begin
        cross_next = OW'(cr1_reg) - OW'(cr2_reg);
        ab_next    = OW'(ab1_reg) - OW'(ab2_reg);
        bc_next    = OW'(bc1_reg) - OW'(bc2_reg);
        ca_next    = OW'(ca1_reg) - OW'(ca2_reg);
        e1_next    = $unsigned(sax_reg) + $unsigned(say_reg);
        e2_next    = $unsigned(sbx_reg) + $unsigned(sby_reg);
        e3_next    = $unsigned(scx_reg) + $unsigned(scy_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            cross_reg <= cross_next;
            ab_reg    <= ab_next;
            bc_reg    <= bc_next;
            ca_reg    <= ca_next;
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            e3_reg    <= e3_next;
        end
    end

    assign out_valid  = v3_reg;
    assign cross_prod = cross_reg;
    assign ab         = ab_reg;
    assign bc         = bc_reg;
    assign ca         = ca_reg;
    assign e1         = e1_reg;
    assign e2         = e2_reg;
    assign e3         = e3_reg;

endmodule

[sv/tpl_order.sv]
module tpl_order #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tpl_pkg::EDGE_TOL_W-1:0]      edge_tol,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [2*COORD_WIDTH+2:0]     cross_prod,
    input  logic signed [2*COORD_WIDTH+2:0]     ab,
    input  logic signed [2*COORD_WIDTH+2:0]     bc,
    input  logic signed [2*COORD_WIDTH+2:0]     ca,
    input  logic        [2*COORD_WIDTH+1:0]     e1,
    input  logic        [2*COORD_WIDTH+1:0]     e2,
    input  logic        [2*COORD_WIDTH+1:0]     e3,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [2*COORD_WIDTH+2:0]     ab_out,
    output logic signed [2*COORD_WIDTH+2:0]     bc_out,
    output logic signed [2*COORD_WIDTH+2:0]     ca_out,
    output logic        [2*COORD_WIDTH+1:0]     e1_out,
    output logic        [2*COORD_WIDTH+1:0]     e2_out,
    output logic        [2*COORD_WIDTH+1:0]     e3_out,
    output tpl_pkg::tpl_side_t                  side,
    output logic [tpl_pkg::AREA_W-1:0]          area
);

    localparam int OW  = 2 * COORD_WIDTH + 3;
    localparam int EW  = 2 * COORD_WIDTH + 2;
    localparam int CW  = (OW > tpl_pkg::EDGE_TOL_W + 1 ? OW : tpl_pkg::EDGE_TOL_W + 1) + 1;
    localparam int AXW = (OW > tpl_pkg::AREA_W ? OW : tpl_pkg::AREA_W);

    logic                     v_reg;
    logic                     rdy;
    logic signed [CW-1:0]     tol_s;
    logic                     swap;
    logic [1:0]               f_ab, f_bc, f_ca;
    logic [OW-1:0]            cross_abs;
    logic [AXW-1:0]           cross_abs_x;

    logic signed [OW-1:0]     ab_next, bc_next, ca_next;
    logic        [EW-1:0]     e2_next, e3_next;
    tpl_pkg::tpl_side_t       side_next;
    logic [tpl_pkg::AREA_W-1:0] area_next;

    logic signed [OW-1:0]     ab_reg, bc_reg, ca_reg;
    logic        [EW-1:0]     e1_reg, e2_reg, e3_reg;
    tpl_pkg::tpl_side_t       side_reg;
    logic [tpl_pkg::AREA_W-1:0] area_reg;

    // {above +tol, below -tol} of one orientation value
    function automatic logic [1:0] tol_flags(input logic signed [OW-1:0] v,
                                             input logic signed [CW-1:0] t);
        logic signed [CW-1:0] ve;
        logic signed [CW-1:0] lo_sum;
        ve     = CW'(v);
        lo_sum = ve + t;
        return {ve > t, lo_sum[CW-1]};
    endfunction

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_valid;
        end
    end

    // Order the vertices, flags and area all from the unordered values
    always_comb begin
        tol_s       = $signed(CW'(edge_tol));
        swap        = CW'(cross_prod) < tol_s;
        f_ab        = tol_flags(ab, tol_s);
        f_bc        = tol_flags(bc, tol_s);
        f_ca        = tol_flags(ca, tol_s);
        cross_abs   = cross_prod[OW-1] ? (~$unsigned(cross_prod) + 1'b1) :
                      $unsigned(cross_prod);
        cross_abs_x = AXW'(cross_abs);
        area_next   = (cross_abs_x > AXW'(tpl_pkg::AREA_MAX)) ? tpl_pkg::AREA_MAX :
                      cross_abs_x[tpl_pkg::AREA_W-1:0];

        side_next.swapped = swap;
        if (swap) begin
            // exchanging B and C negates the orientations, swaps ab with ca and e2 with e3
            ab_next         = -ca;
            bc_next         = -bc;
            ca_next         = -ab;
            e2_next         = e3;
            e3_next         = e2;
            side_next.ab_gt = f_ca[0];
            side_next.ab_lt = f_ca[1];
            side_next.bc_gt = f_bc[0];
            side_next.bc_lt = f_bc[1];
            side_next.ca_gt = f_ab[0];
            side_next.ca_lt = f_ab[1];
        end else begin
            ab_next         = ab;
            bc_next         = bc;
            ca_next         = ca;
            e2_next         = e2;
            e3_next         = e3;
            side_next.ab_gt = f_ab[1];
            side_next.ab_lt = f_ab[0];
            side_next.bc_gt = f_bc[1];
            side_next.bc_lt = f_bc[0];
            side_next.ca_gt = f_ca[1];
            side_next.ca_lt = f_ca[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy && in_valid) begin
            ab_reg   <= ab_next;
            bc_reg   <= bc_next;
            ca_reg   <= ca_next;
            e1_reg   <= e1;
            e2_reg   <= e2_next;
            e3_reg   <= e3_next;
            side_reg <= side_next;
            area_reg <= area_next;
        end
    end

    assign out_valid = v_reg;
    assign ab_out    = ab_reg;
    assign bc_out    = bc_reg;
    assign ca_out    = ca_reg;
    assign e1_out    = e1_reg;
    assign e2_out    = e2_reg;
    assign e3_out    = e3_reg;
    assign side      = side_reg;
    assign area      = area_reg;

endmodule

[sv/tpl_incircle.sv]
module tpl_incircle #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [tpl_pkg::INC_TOL_W-1:0]       incircle_tol,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [2*COORD_WIDTH+2:0]     ab,
    input  logic signed [2*COORD_WIDTH+2:0]     bc,
    input  logic signed [2*COORD_WIDTH+2:0]     ca,
    input  logic        [2*COORD_WIDTH+1:0]     e1,
    input  logic        [2*COORD_WIDTH+1:0]     e2,
    input  logic        [2*COORD_WIDTH+1:0]     e3,
    input  tpl_pkg::tpl_side_t                  side,
    input  logic [tpl_pkg::AREA_W-1:0]          area,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tpl_pkg::loc_t                       location,
    output logic                                in_circle,
    output logic                                swapped,
    output logic [tpl_pkg::AREA_W-1:0]          double_area
);

    localparam int OW  = 2 * COORD_WIDTH + 3;
    localparam int EW  = 2 * COORD_WIDTH + 2;
    localparam int HW  = COORD_WIDTH + 1;
    localparam int PPW = OW + HW + 1;
    localparam int TW  = OW + EW + 1;
    localparam int CMW = (TW > 64 ? TW : 64) + 1;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: half-width partial products of the lifted determinant
    logic signed [PPW-1:0] p1l_next, p1h_next, p2l_next, p2h_next, p3l_next, p3h_next;
    logic signed [PPW-1:0] p1l_reg, p1h_reg, p2l_reg, p2h_reg, p3l_reg, p3h_reg;
    tpl_pkg::tpl_side_t    side1_reg;
    logic [tpl_pkg::AREA_W-1:0] area1_reg;

    // Stage 2: full terms
    logic signed [TW-1:0]  t1_next, t2_next, t3_next;
    logic signed [TW-1:0]  t1_reg, t2_reg, t3_reg;
    tpl_pkg::tpl_side_t    side2_reg;
    logic [tpl_pkg::AREA_W-1:0] area2_reg;

    // Stage 3: determinant
    logic signed [TW-1:0]  det_next;
    logic signed [TW-1:0]  det_reg;
    tpl_pkg::tpl_side_t    side3_reg;
    logic [tpl_pkg::AREA_W-1:0] area3_reg;

    // Stage 4: classification, result register
    logic                  above;
    logic                  all_gt, all_lt;
    logic                  sm_ab, sm_bc, sm_ca;
    tpl_pkg::loc_t         loc_next;
    tpl_pkg::loc_t         loc_reg;
    logic                  in_circle_reg;
    logic                  swapped_reg;
    logic [tpl_pkg::AREA_W-1:0] area4_reg;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Split each lift value into two halves to keep the multipliers narrow
    always_comb begin
        p1l_next = PPW'(bc) * $signed(PPW'(e1[HW-1:0]));
        p1h_next = PPW'(bc) * $signed(PPW'(e1[EW-1:HW]));
        p2l_next = PPW'(ca) * $signed(PPW'(e2[HW-1:0]));
        p2h_next = PPW'(ca) * $signed(PPW'(e2[EW-1:HW]));
        p3l_next = PPW'(ab) * $signed(PPW'(e3[HW-1:0]));
        p3h_next = PPW'(ab) * $signed(PPW'(e3[EW-1:HW]));
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            p1l_reg   <= p1l_next;
            p1h_reg   <= p1h_next;
            p2l_reg   <= p2l_next;
            p2h_reg   <= p2h_next;
            p3l_reg   <= p3l_next;
            p3h_reg   <= p3h_next;
            side1_reg <= side;
            area1_reg <= area;
        end
    end

    always_comb begin
        t1_next = (TW'(p1h_reg) <<< HW) + TW'(p1l_reg);
        t2_next = (TW'(p2h_reg) <<< HW) + TW'(p2l_reg);
        t3_next = (TW'(p3h_reg) <<< HW) + TW'(p3l_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            t3_reg    <= t3_next;
            side2_reg <= side1_reg;
            area2_reg <= area1_reg;
        end
    end

    assign det_next = t1_reg + t2_reg + t3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            det_reg   <= det_next;
            side3_reg <= side2_reg;
            area3_reg <= area2_reg;
        end
    end

    // Determinant above incircle_tol first, then the edge tests on ab, bc and ca
    always_comb begin
        above  = CMW'(det_reg) > $signed(CMW'(incircle_tol));
        all_gt = side3_reg.ab_gt && side3_reg.bc_gt && side3_reg.ca_gt;
        all_lt = side3_reg.ab_lt && side3_reg.bc_lt && side3_reg.ca_lt;
        sm_ab  = !side3_reg.ab_gt && !side3_reg.ab_lt;
        sm_bc  = !side3_reg.bc_gt && !side3_reg.bc_lt;
        sm_ca  = !side3_reg.ca_gt && !side3_reg.ca_lt;
        if (!above) begin
            loc_next = tpl_pkg::LOC_OUTSIDE;
        end else if (all_gt || all_lt) begin
            loc_next = tpl_pkg::LOC_INSIDE;
        end else if ((sm_ab && !sm_bc && !sm_ca) || (!sm_ab && sm_bc && !sm_ca) ||
                     (!sm_ab && !sm_bc && sm_ca)) begin
            loc_next = tpl_pkg::LOC_EDGE;
        end else begin
            loc_next = tpl_pkg::LOC_OUTSIDE;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            loc_reg       <= loc_next;
            in_circle_reg <= above;
            swapped_reg   <= side3_reg.swapped;
            area4_reg     <= area3_reg;
        end
    end

    assign out_valid   = v4_reg;
    assign location    = loc_reg;
    assign in_circle   = in_circle_reg;
    assign swapped     = swapped_reg;
    assign double_area = area4_reg;

endmodule

[sim/tpl_checker.sv]
`timescale 1ns / 100ps
module tpl_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // ax, ay, bx, by_coord, cx, cy, px, py from the lowest bit up
    input  logic [8*COORD_WIDTH-1:0]            s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // location, in_circle, swapped, double_area, zero pad from the lowest bit up
    input  logic [tpl_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tpl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tpl_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                  errors,
    output int                                  pending,
    output int                                  n_results,
    output int                                  n_inside,
    output int                                  n_edge,
    output int                                  n_circle,
    output int                                  n_swapped
);

    typedef struct packed {
        tpl_pkg::loc_t                location;
        logic                         in_circle;
        logic                         swapped;
        logic [tpl_pkg::AREA_W-1:0]   double_area;
    } locate_res_t;

    locate_res_t                          expected_q[$];
    logic [tpl_pkg::INC_TOL_W-1:0]        incircle_tol = '0;
    logic [tpl_pkg::EDGE_TOL_W-1:0]       edge_tol     = '0;
    int                                   fail_cnt     = 0;
    int                                   res_cnt      = 0;
    int                                   inside_cnt   = 0;
    int                                   edge_cnt     = 0;
    int                                   circle_cnt   = 0;
    int                                   swap_cnt     = 0;

    assign errors    = fail_cnt;
    assign n_results = res_cnt;
    assign n_inside  = inside_cnt;
    assign n_edge    = edge_cnt;
    assign n_circle  = circle_cnt;
    assign n_swapped = swap_cnt;

    function automatic longint coord_at(input logic [8*COORD_WIDTH-1:0] pkt, input int idx);
        logic signed [COORD_WIDTH-1:0] c;
        c = pkt[idx*COORD_WIDTH +: COORD_WIDTH];
        return longint'(c);
    endfunction

    // Order the vertices, then run the incircle and edge orientation tests
    function automatic locate_res_t locate_point(input logic [8*COORD_WIDTH-1:0] pkt);
        longint ax, ay, bx, by, cx, cy, px, py;
        longint tmp, tol, cross_prod, mag;
        longint dax, day, dbx, dby, dcx, dcy, ab, bc, ca;
        int n_small;
        logic signed [127:0] w_ab, w_bc, w_ca, w_e1, w_e2, w_e3, det, thr;
        locate_res_t r;
        ax = coord_at(pkt, 0);
        ay = coord_at(pkt, 1);
        bx = coord_at(pkt, 2);
        by = coord_at(pkt, 3);
        cx = coord_at(pkt, 4);
        cy = coord_at(pkt, 5);
        px = coord_at(pkt, 6);
        py = coord_at(pkt, 7);
        tol = longint'({30'd0, edge_tol});
        r.location = tpl_pkg::LOC_OUTSIDE;
        r.in_circle = 1'b0;
        r.swapped = 1'b0;

        // Exchange B and C when the winding is not clearly counterclockwise
        cross_prod = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        if (cross_prod < tol) begin
            r.swapped = 1'b1;
            tmp = bx; bx = cx; cx = tmp;
            tmp = by; by = cy; cy = tmp;
        end
        mag = (cross_prod < 0) ? -cross_prod : cross_prod;
        if (mag > longint'({30'd0, tpl_pkg::AREA_MAX}))
            r.double_area = tpl_pkg::AREA_MAX;
        else
            r.double_area = mag[tpl_pkg::AREA_W-1:0];

        // Exact lifted incircle determinant
        dax = ax - px; day = ay - py;
        dbx = bx - px; dby = by - py;
        dcx = cx - px; dcy = cy - py;
        ab = dax * dby - day * dbx;
        bc = dbx * dcy - dby * dcx;
        ca = dcx * day - dax * dcy;
        w_ab = ab;
        w_bc = bc;
        w_ca = ca;
        w_e1 = dax * dax + day * day;
        w_e2 = dbx * dbx + dby * dby;
        w_e3 = dcx * dcx + dcy * dcy;
        det = w_bc * w_e1 + w_ca * w_e2 + w_ab * w_e3;
        thr = {65'd0, incircle_tol};

        // Classify against the edges only when inside the circumcircle
        if (det > thr) begin
            r.in_circle = 1'b1;
            n_small = 0;
            if (ab <= tol && ab >= -tol) n_small++;
            if (bc <= tol && bc >= -tol) n_small++;
            if (ca <= tol && ca >= -tol) n_small++;
            if ((ab > tol && bc > tol && ca > tol) ||
                (ab < -tol && bc < -tol && ca < -tol))
                r.location = tpl_pkg::LOC_INSIDE;
            else if (n_small == 1)
                r.location = tpl_pkg::LOC_EDGE;
        end
        return r;
    endfunction

    task automatic report(input string what, input longint unsigned want_v,
                          input longint unsigned got_v);
        fail_cnt++;
        if (fail_cnt <= 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    // Track configuration, queue predictions, compare results
    always @(posedge aclk) begin : watch
        locate_res_t want;
        logic [1:0] got_loc;
        if (!aresetn) begin
            expected_q.delete();
            incircle_tol = '0;
            edge_tol = '0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tpl_pkg::REG_INCIRCLE_TOL:
                        incircle_tol = cfg_data[tpl_pkg::INC_TOL_W-1:0];
                    tpl_pkg::REG_EDGE_TOL:
                        edge_tol = cfg_data[tpl_pkg::EDGE_TOL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.insert(expected_q.size(), locate_point(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 40)
                        $display("%0t: unexpected result transaction, tdata %h", $time, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    got_loc = m_tdata[1:0];
                    if (got_loc != want.location)
                        report("location", want.location, got_loc);
                    if (m_tdata[2] != want.in_circle)
                        report("in_circle", want.in_circle, m_tdata[2]);
                    if (m_tdata[3] != want.swapped)
                        report("swapped", want.swapped, m_tdata[3]);
                    if (m_tdata[4 +: tpl_pkg::AREA_W] != want.double_area)
                        report("double_area", want.double_area, m_tdata[4 +: tpl_pkg::AREA_W]);
                    if (m_tdata[tpl_pkg::OUT_TDATA_W-1:tpl_pkg::OUT_FIELDS_W] != '0)
                        report("pad", 0, m_tdata[tpl_pkg::OUT_TDATA_W-1:tpl_pkg::OUT_FIELDS_W]);
                    res_cnt++;
                    if (want.location == tpl_pkg::LOC_INSIDE) inside_cnt++;
                    if (want.location == tpl_pkg::LOC_EDGE) edge_cnt++;
                    if (want.in_circle) circle_cnt++;
                    if (want.swapped) swap_cnt++;
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

    localparam int COORD_W        = 16;
    localparam int N_PHASES       = 8;
    localparam int RAND_PER_PHASE = 135;
    localparam int C_MAX          = (1 << (COORD_W - 1)) - 1;
    localparam int C_MIN          = -C_MAX - 1;

    // Indexes that map to no register
    localparam logic [tpl_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [tpl_pkg::CFG_IDX_W-1:0] REG_LAST  = 8'hFF;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [8*COORD_W-1:0]                s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [tpl_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [tpl_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [tpl_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    int errors, pending, n_results, n_inside, n_edge, n_circle, n_swapped;
    int burst_left = 0;
    int stall_cyc  = 0;

    triangle_point_locate #(.COORD_WIDTH(COORD_W)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tpl_checker #(.COORD_WIDTH(COORD_W)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .n_results(n_results),
        .n_inside(n_inside), .n_edge(n_edge), .n_circle(n_circle),
        .n_swapped(n_swapped)
    );

    always #1 aclk = ~aclk;

    // Hard stop for a hung handshake
    initial begin
        #2_000_000;
        $display("[triangle_point_locate] ERROR");
        $finish;
    end

    // Receiver stalls: always ready, random, periodic, long on/off runs
    always @(negedge aclk) begin
        stall_cyc <= stall_cyc + 1;
        case (stall_cyc[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ((stall_cyc % 5) < 2);
            default: m_tready <= stall_cyc[3];
        endcase
    end

    function automatic logic [COORD_W-1:0] clip(input int v);
        int c;
        c = (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
        return c[COORD_W-1:0];
    endfunction

    function automatic logic [8*COORD_W-1:0] pack_pts(input int ax, ay, bx, by,
                                                     input int cx, cy, px, py);
        return {clip(py), clip(px), clip(cy), clip(cx),
                clip(by), clip(bx), clip(ay), clip(ax)};
    endfunction

    function automatic int srand(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return 0;
            3: return -1;
            default: return srand(C_MAX);
        endcase
    endfunction

    // Mostly well-formed geometry around the triangle, some pure noise
    function automatic logic [8*COORD_W-1:0] random_query();
        int kind, r, base_x, base_y, ax, ay, bx, by, cx, cy, px, py, dx, dy;
        logic [8*COORD_W-1:0] raw;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: r = 4;
            1: r = 64;
            2: r = 2048;
            default: r = 16383;
        endcase
        base_x = srand(16384);
        base_y = srand(16384);
        ax = base_x + srand(r); ay = base_y + srand(r);
        bx = base_x + srand(r); by = base_y + srand(r);
        cx = base_x + srand(r); cy = base_y + srand(r);
        px = (ax + bx + cx) / 3 + srand(r / 2);
        py = (ay + by + cy) / 3 + srand(r / 2);
        dx = srand(r / 2);
        dy = srand(r / 2);
        case (kind)
            0, 1: begin
                for (int i = 0; i < 8; i++)
                    raw[i*COORD_W +: COORD_W] = COORD_W'($urandom);
                return raw;
            end
            5, 6: begin
                // point on the segment from A to B
                bx = ax + 2 * dx; by = ay + 2 * dy;
                px = ax + dx; py = ay + dy;
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: begin
                        // collinear vertices
                        bx = ax + dx; by = ay + dy;
                        cx = ax + 3 * dx; cy = ay + 3 * dy;
                    end
                    1: begin px = ax; py = ay; end
                    2: begin px = bx; py = by; end
                    default: begin px = cx; py = cy; end
                endcase
            end
            8: begin
                ax = pick_extreme(); ay = pick_extreme();
                bx = pick_extreme(); by = pick_extreme();
                cx = pick_extreme(); cy = pick_extreme();
                px = pick_extreme(); py = pick_extreme();
            end
            9: begin
                px = (ax + bx + cx) / 3 + srand(2 * r);
                py = (ay + by + cy) / 3 + srand(2 * r);
            end
            default: ;
        endcase
        return pack_pts(ax, ay, bx, by, cx, cy, px, py);
    endfunction

    // Drive one transaction, opening a new burst after a random gap
    task automatic send_item(input logic [8*COORD_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Hold off until every result is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [tpl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpl_pkg::CFG_DATA_W-1:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_directed();
        // inside, on an edge, outside the circle, in circle but outside triangle
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 20, 20));
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 50, 0));
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 1000, 1000));
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 90, 90));
        // clockwise input, collinear vertices, point on a vertex
        send_item(pack_pts(0, 0, 0, 100, 100, 0, 20, 20));
        send_item(pack_pts(0, 0, 50, 50, 100, 100, 10, 0));
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 0, 0));
        // full-scale coordinates
        send_item(pack_pts(C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0));
        send_item(pack_pts(C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0));
        send_item(pack_pts(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_item(pack_pts(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_item(pack_pts(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN));
        // near an edge and near corners, sensitive to edge_tol
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 50, 1));
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 1, 1));
        send_item(pack_pts(0, 0, 100, 0, 0, 100, 99, 1));
        // all points equal, tiny triangles, larger triangles with P inside and just outside
        send_item(pack_pts(10, 10, 10, 10, 10, 10, 10, 10));
        send_item(pack_pts(0, 0, 1, 0, 0, 1, 0, 0));
        send_item(pack_pts(-1, -1, 1, -1, -1, 1, 0, 0));
        send_item(pack_pts(0, 0, 200, 0, 100, 173, 100, 58));
        send_item(pack_pts(0, 0, 200, 0, 100, 173, 100, -5));
        send_item(pack_pts(0, 0, -100, 0, 0, -100, -20, -20));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // Retune the tolerances only with the pipeline empty
            if (ph > 0) begin
                drain();
                case (ph)
                    1: cfg_write(tpl_pkg::REG_INCIRCLE_TOL, '1);
                    2: begin
                        cfg_write(tpl_pkg::REG_INCIRCLE_TOL, '0);
                        cfg_write(tpl_pkg::REG_EDGE_TOL, '1);
                    end
                    3: begin
                        cfg_write(tpl_pkg::REG_INCIRCLE_TOL, 64'd1_000_000);
                        cfg_write(tpl_pkg::REG_EDGE_TOL, 64'd1000);
                    end
                    4: begin
                        cfg_write(tpl_pkg::REG_INCIRCLE_TOL, {24'd0, $urandom, 8'd0});
                        cfg_write(tpl_pkg::REG_EDGE_TOL, 64'($urandom_range(0, 1 << 20)));
                    end
                    5: begin
                        cfg_write(REG_SPARE, '1);
                        cfg_write(REG_LAST, '1);
                        cfg_write(tpl_pkg::REG_EDGE_TOL, 64'hFFFF_FFFC_0000_0000);
                        cfg_write(tpl_pkg::REG_INCIRCLE_TOL, 64'h8000_0000_0000_0000);
                    end
                    6: begin
                        cfg_write(tpl_pkg::REG_INCIRCLE_TOL, {24'd0, 8'($urandom), $urandom});
                        cfg_write(tpl_pkg::REG_EDGE_TOL, 64'd8589934592);
                    end
                    default: begin
                        cfg_write(tpl_pkg::REG_INCIRCLE_TOL, 64'd1);
                        cfg_write(tpl_pkg::REG_EDGE_TOL, 64'd1);
                    end
                endcase
            end
            if (ph == 0 || ph == 3)
                run_directed();
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_item(random_query());
        end

        drain();
        $display("%0d results checked over %0d tolerance settings, zero and full scale included",
                 n_results, N_PHASES);
        $display("inside %0d, on an edge %0d, in circumcircle %0d, B and C exchanged %0d",
                 n_inside, n_edge, n_circle, n_swapped);
        if (errors == 0)
            $display("[triangle_point_locate] OK");
        else
            $display("[triangle_point_locate] ERROR");
        $finish;
    end

endmodule

[triangle_point_locate.f]
sv/tpl_pkg.sv
sv/tpl_geom.sv
sv/tpl_order.sv
sv/tpl_incircle.sv
sv/triangle_point_locate.sv
sim/tpl_checker.sv
sim/tb_top.sv
